@@ design/gfba_pkg.sv @@
package gfba_pkg;

   // sizing of the free list and the group store
   localparam int GROUP_SIZE  = 50;
   localparam int BLOCK_BITS  = 16;
   localparam int MAX_GROUPS  = 64;
   localparam int WORD_W      = 16;
   localparam int WORDS       = GROUP_SIZE + 1;
   localparam int TOP_W       = $clog2(GROUP_SIZE + 1);
   localparam int STK_AW      = $clog2(GROUP_SIZE);
   localparam int DEPTH_W     = $clog2(MAX_GROUPS + 1);
   localparam int STORE_DEPTH = MAX_GROUPS * WORDS;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   localparam logic [WORD_W-1:0] BLK_MASK =
      (BLOCK_BITS >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((1 << BLOCK_BITS) - 1);
   localparam logic [WORD_W-1:0] COUNT_MAX = {WORD_W{1'b1}};

   // request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // response status codes
   typedef enum logic [1:0] {
      ST_ALLOC = 2'd0,
      ST_FULL  = 2'd1,
      ST_FREED = 2'd2,
      ST_OVF   = 2'd3
   } status_type;

   // microprogram addresses
   typedef enum logic [4:0] {
      P_IDLE,
      P_DISPATCH,
      P_A_CHK,
      P_A_GOT,
      P_A_RLD,
      P_A_RLD_RD,
      P_A_RLD_WR,
      P_A_RLD_END,
      P_A_POP,
      P_F_CHK,
      P_F_TOP,
      P_F_DEPTH,
      P_F_SPL_RD,
      P_F_SPL_WR,
      P_F_SPL_END,
      P_F_PUSH,
      P_R_FULL,
      P_R_OVF
   } step_type;

   // jump conditions
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_OP_FREE,
      C_CNT_ZERO,
      C_NO_RELOAD,
      C_IDX_MORE,
      C_CNT_MAX,
      C_TOP_ROOM,
      C_STORE_FULL
   } cond_type;

   // one horizontal control word
   typedef struct packed {
      cond_type   cond;
      step_type   target;
      logic       stk_rd_top;
      logic       stk_rd_idx;
      logic       grp_rd;
      logic       grp_wr;
      logic       stk_load;
      logic       take_got;
      logic       pop;
      logic       push;
      logic       reload_setup;
      logic       spill_setup;
      logic       spill_end;
      logic       top_full;
      logic       cnt_dec;
      logic       cnt_inc;
      logic       resp;
      status_type status;
   } ctrl_word_type;

   // control store
   function automatic ctrl_word_type program_rom(step_type pc);
      ctrl_word_type w;
      w        = '0;
      w.cond   = C_NEVER;
      w.target = P_IDLE;
      w.status = ST_ALLOC;
      unique case (pc)
         P_IDLE: begin
            w.cond   = C_NO_REQ;
            w.target = P_IDLE;
         end
         P_DISPATCH: begin
            w.stk_rd_top = 1'b1;
            w.cond       = C_OP_FREE;
            w.target     = P_F_CHK;
         end
         P_A_CHK: begin
            w.cond   = C_CNT_ZERO;
            w.target = P_R_FULL;
         end
         P_A_GOT: begin
            w.take_got = 1'b1;
            w.cond     = C_NO_RELOAD;
            w.target   = P_A_POP;
         end
         P_A_RLD: begin
            w.reload_setup = 1'b1;
         end
         P_A_RLD_RD: begin
            w.grp_rd = 1'b1;
         end
         P_A_RLD_WR: begin
            w.stk_load = 1'b1;
            w.cond     = C_IDX_MORE;
            w.target   = P_A_RLD_RD;
         end
         P_A_RLD_END: begin
            w.top_full = 1'b1;
            w.cnt_dec  = 1'b1;
            w.resp     = 1'b1;
            w.status   = ST_ALLOC;
            w.cond     = C_ALWAYS;
            w.target   = P_IDLE;
         end
         P_A_POP: begin
            w.pop     = 1'b1;
            w.cnt_dec = 1'b1;
            w.resp    = 1'b1;
            w.status  = ST_ALLOC;
            w.cond    = C_ALWAYS;
            w.target  = P_IDLE;
         end
         P_F_CHK: begin
            w.cond   = C_CNT_MAX;
            w.target = P_R_OVF;
         end
         P_F_TOP: begin
            w.cond   = C_TOP_ROOM;
            w.target = P_F_PUSH;
         end
         P_F_DEPTH: begin
            w.spill_setup = 1'b1;
            w.cond        = C_STORE_FULL;
            w.target      = P_R_OVF;
         end
         P_F_SPL_RD: begin
            w.stk_rd_idx = 1'b1;
         end
         P_F_SPL_WR: begin
            w.grp_wr = 1'b1;
            w.cond   = C_IDX_MORE;
            w.target = P_F_SPL_RD;
         end
         P_F_SPL_END: begin
            w.spill_end = 1'b1;
            w.cnt_inc   = 1'b1;
            w.resp      = 1'b1;
            w.status    = ST_FREED;
            w.cond      = C_ALWAYS;
            w.target    = P_IDLE;
         end
         P_F_PUSH: begin
            w.push    = 1'b1;
            w.cnt_inc = 1'b1;
            w.resp    = 1'b1;
            w.status  = ST_FREED;
            w.cond    = C_ALWAYS;
            w.target  = P_IDLE;
         end
         P_R_FULL: begin
            w.resp   = 1'b1;
            w.status = ST_FULL;
            w.cond   = C_ALWAYS;
            w.target = P_IDLE;
         end
         P_R_OVF: begin
            w.resp   = 1'b1;
            w.status = ST_OVF;
            w.cond   = C_ALWAYS;
            w.target = P_IDLE;
         end
         default: begin
            w.cond   = C_ALWAYS;
            w.target = P_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

@@ design/gfba_req_if.sv @@
interface gfba_req_if;
   logic                           valid;
   logic                           ready;
   logic                           opcode;
   logic [gfba_pkg::WORD_W-1:0]    block_number;

   modport source (output valid, output opcode, output block_number, input ready);
   modport sink (input valid, input opcode, input block_number, output ready);
endinterface

@@ design/gfba_rsp_if.sv @@
interface gfba_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [gfba_pkg::WORD_W-1:0]    allocated_block;
   logic [1:0]                     status;
   logic [gfba_pkg::WORD_W-1:0]    free_total;

   modport source (output valid, output allocated_block, output status,
                   output free_total, input ready);
   modport sink (input valid, input allocated_block, input status,
                 input free_total, output ready);
endinterface

@@ design/grouped_free_block_allocator.sv @@
// one transaction at a time: a request is taken only in the idle step, and the
// next one waits until the microprogram walk for the last returns there; spill
// and reload copy the 51-word group image word by word through a read step and a
// write step in a loop
// reset: control, counters and stack valid bits clear at once; the group store
// is not cleared and holds undefined data until spilled into
module grouped_free_block_allocator (
   input  logic         clock,
   input  logic         reset,
   gfba_req_if.sink     req_chan,
   gfba_rsp_if.source   rsp_chan
);

   localparam int W = gfba_pkg::WORD_W;

   // sequencer
   gfba_pkg::step_type      pc_ff, pc_in;
   gfba_pkg::ctrl_word_type ctrl;
   logic                    cond_true;
   logic                    stall;
   logic                    go;
   logic                    req_accept;
   logic                    reload_need;

   // request latch and working registers
   logic                             op_ff, op_in;
   logic [W-1:0]                     blk_ff, blk_in;
   logic [W-1:0]                     got_ff, got_in;
   logic [gfba_pkg::TOP_W-1:0]       idx_ff, idx_in;
   logic [gfba_pkg::TOP_W-1:0]       top_ff, top_in;
   logic [W-1:0]                     count_word_ff, count_word_in;
   logic [W-1:0]                     free_count_ff, free_count_in;
   logic                             dirty_ff, dirty_in;
   logic [gfba_pkg::DEPTH_W-1:0]     depth_ff, depth_in;
   logic [gfba_pkg::STORE_AW-1:0]    base_ff, base_in;

   // response register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]                     rsp_block_ff, rsp_block_in;
   gfba_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [W-1:0]                     rsp_total_ff, rsp_total_in;

   // working stack memory, words 1 to GROUP_SIZE
   logic [W-1:0]                     stk_mem [gfba_pkg::GROUP_SIZE];
   logic [gfba_pkg::GROUP_SIZE-1:0]  stk_vld_ff;
   logic                             stk_re, stk_we;
   logic [gfba_pkg::STK_AW-1:0]      stk_rd_addr, stk_wr_addr;
   logic [W-1:0]                     stk_wr_data;
   logic [W-1:0]                     stk_rd_data_ff;
   logic                             stk_rd_vld_ff;

   // group image store
   logic [W-1:0]                     grp_mem [gfba_pkg::STORE_DEPTH];
   logic                             grp_re, grp_we;
   logic [gfba_pkg::STORE_AW-1:0]    grp_addr;
   logic [W-1:0]                     grp_wr_data;
   logic [W-1:0]                     grp_rd_data_ff;

   assign req_accept = req_chan.valid && req_chan.ready;

   // control word fetch and condition select
   always_comb begin
      ctrl        = gfba_pkg::program_rom(pc_ff);
      reload_need = (free_count_ff != W'(1)) && (top_ff == gfba_pkg::TOP_W'(1)) &&
                    (depth_ff != '0);
      unique case (ctrl.cond)
         gfba_pkg::C_NEVER:      cond_true = 1'b0;
         gfba_pkg::C_ALWAYS:     cond_true = 1'b1;
         gfba_pkg::C_NO_REQ:     cond_true = !req_chan.valid;
         gfba_pkg::C_OP_FREE:    cond_true = (op_ff == gfba_pkg::OP_FREE);
         gfba_pkg::C_CNT_ZERO:   cond_true = (free_count_ff == '0);
         gfba_pkg::C_NO_RELOAD:  cond_true = !reload_need;
         gfba_pkg::C_IDX_MORE:   cond_true = (idx_ff != gfba_pkg::TOP_W'(gfba_pkg::GROUP_SIZE));
         gfba_pkg::C_CNT_MAX:    cond_true = (free_count_ff == gfba_pkg::COUNT_MAX);
         gfba_pkg::C_TOP_ROOM:   cond_true = (top_ff < gfba_pkg::TOP_W'(gfba_pkg::GROUP_SIZE));
         gfba_pkg::C_STORE_FULL: cond_true =
            (depth_ff >= gfba_pkg::DEPTH_W'(gfba_pkg::MAX_GROUPS));
         default:                cond_true = 1'b0;
      endcase
      stall = ctrl.resp && rsp_valid_ff && !rsp_chan.ready;
      go    = !stall;
   end

   // next step
   always_comb begin
      if (stall) begin
         pc_in = pc_ff;
      end else if (cond_true) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = gfba_pkg::step_type'(pc_ff + 5'd1);
      end
   end

   // handshake outputs
   assign req_chan.ready           = (pc_ff == gfba_pkg::P_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.allocated_block = rsp_block_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.free_total      = rsp_total_ff;

   // datapath next values
   always_comb begin
      op_in         = op_ff;
      blk_in        = blk_ff;
      got_in        = got_ff;
      idx_in        = idx_ff;
      top_in        = top_ff;
      count_word_in = count_word_ff;
      free_count_in = free_count_ff;
      dirty_in      = dirty_ff;
      depth_in      = depth_ff;
      base_in       = base_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;

      if (req_accept) begin
         op_in  = req_chan.opcode;
         blk_in = req_chan.block_number & gfba_pkg::BLK_MASK;
      end

      if (go) begin
         // block handed out comes from the top word
         if (ctrl.take_got) begin
            if (top_ff == '0) begin
               got_in = count_word_ff;
            end else begin
               got_in = stk_rd_vld_ff ? stk_rd_data_ff : '0;
            end
         end
         if (ctrl.pop) begin
            if (top_ff != '0) begin
               top_in = top_ff - 1'b1;
            end
            if (count_word_ff != '0) begin
               count_word_in = count_word_ff - 1'b1;
            end
         end
         if (ctrl.push) begin
            top_in        = top_ff + 1'b1;
            count_word_in = (count_word_ff + 1'b1) & gfba_pkg::BLK_MASK;
         end
         // copy loop bookkeeping
         if (ctrl.reload_setup) begin
            depth_in = depth_ff - 1'b1;
            base_in  = base_ff - gfba_pkg::STORE_AW'(gfba_pkg::WORDS);
            idx_in   = '0;
         end
         if (ctrl.spill_setup) begin
            idx_in = '0;
         end
         if (ctrl.stk_load || ctrl.grp_wr) begin
            idx_in = idx_ff + 1'b1;
         end
         if (ctrl.stk_load && (idx_ff == '0)) begin
            count_word_in = grp_rd_data_ff;
         end
         if (ctrl.top_full) begin
            top_in = gfba_pkg::TOP_W'(gfba_pkg::GROUP_SIZE);
         end
         // freed block becomes the new group leader
         if (ctrl.spill_end) begin
            depth_in      = depth_ff + 1'b1;
            base_in       = base_ff + gfba_pkg::STORE_AW'(gfba_pkg::WORDS);
            top_in        = gfba_pkg::TOP_W'(1);
            count_word_in = W'(1);
         end
         if (ctrl.cnt_dec) begin
            free_count_in = free_count_ff - 1'b1;
            dirty_in      = 1'b1;
         end
         if (ctrl.cnt_inc) begin
            free_count_in = free_count_ff + 1'b1;
            dirty_in      = 1'b1;
         end
         if (ctrl.resp) begin
            rsp_block_in  = (ctrl.status == gfba_pkg::ST_ALLOC) ? got_ff : '0;
            rsp_status_in = ctrl.status;
            rsp_total_in  = free_count_in;
         end
      end

      // response slot
      if (go && ctrl.resp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // stack memory port control
   always_comb begin
      stk_re = ctrl.stk_rd_top || ctrl.stk_rd_idx;
      if (ctrl.stk_rd_top) begin
         stk_rd_addr = (top_ff == '0) ? '0 : gfba_pkg::STK_AW'(top_ff - 1'b1);
      end else begin
         stk_rd_addr = (idx_ff == '0) ? '0 : gfba_pkg::STK_AW'(idx_ff - 1'b1);
      end

      stk_we      = 1'b0;
      stk_wr_addr = '0;
      stk_wr_data = blk_ff;
      if (go) begin
         if (ctrl.stk_load && (idx_ff != '0)) begin
            stk_we      = 1'b1;
            stk_wr_addr = gfba_pkg::STK_AW'(idx_ff - 1'b1);
            stk_wr_data = grp_rd_data_ff;
         end else if (ctrl.push) begin
            stk_we      = 1'b1;
            stk_wr_addr = gfba_pkg::STK_AW'(top_ff);
         end else if (ctrl.spill_end) begin
            stk_we      = 1'b1;
            stk_wr_addr = '0;
         end
      end
   end

   // group store port control
   always_comb begin
      grp_re      = ctrl.grp_rd;
      grp_we      = go && ctrl.grp_wr;
      grp_addr    = base_ff + gfba_pkg::STORE_AW'(idx_ff);
      if (idx_ff == '0) begin
         grp_wr_data = count_word_ff;
      end else begin
         grp_wr_data = stk_rd_vld_ff ? stk_rd_data_ff : '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= gfba_pkg::P_IDLE;
         top_ff        <= '0;
         count_word_ff <= '0;
         free_count_ff <= '0;
         dirty_ff      <= 1'b0;
         depth_ff      <= '0;
         base_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         top_ff        <= top_in;
         count_word_ff <= count_word_in;
         free_count_ff <= free_count_in;
         dirty_ff      <= dirty_in;
         depth_ff      <= depth_in;
         base_ff       <= base_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      blk_ff        <= blk_in;
      got_ff        <= got_in;
      idx_ff        <= idx_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // stack valid bits, an unwritten word reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         stk_vld_ff <= '0;
      end else if (stk_we) begin
         stk_vld_ff[stk_wr_addr] <= 1'b1;
      end
   end

   // stack memory
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wr_addr] <= stk_wr_data;
      end
      if (stk_re) begin
         stk_rd_data_ff <= stk_mem[stk_rd_addr];
         stk_rd_vld_ff  <= stk_vld_ff[stk_rd_addr];
      end
   end

   // group store memory
   always_ff @(posedge clock) begin
      if (grp_we) begin
         grp_mem[grp_addr] <= grp_wr_data;
      end
      if (grp_re) begin
         grp_rd_data_ff <= grp_mem[grp_addr];
      end
   end

endmodule

@@ design/gfba_checker.sv @@
module gfba_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [gfba_pkg::WORD_W-1:0] rsp_allocated_block,
   input logic [1:0]                  rsp_status,
   input logic [gfba_pkg::WORD_W-1:0] rsp_free_total
);

   // a waiting response holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_allocated_block) &&
      $stable(rsp_status) && $stable(rsp_free_total))
      else $error("response changed while stalled");

   // only one transaction is worked on at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // frees and overflow refusals hand out no block
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == gfba_pkg::ST_FREED || rsp_status == gfba_pkg::ST_OVF)
      |-> rsp_allocated_block == '0)
      else $error("block number on a non-allocate response");

   // disk full only with nothing free
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == gfba_pkg::ST_FULL
      |-> rsp_free_total == '0 && rsp_allocated_block == '0)
      else $error("disk full reported with free blocks");

endmodule

bind grouped_free_block_allocator gfba_checker u_gfba_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_allocated_block (rsp_chan.allocated_block),
   .rsp_status          (rsp_chan.status),
   .rsp_free_total      (rsp_chan.free_total)
);
